[rtl/source_tokenizer_top_assert.svh]
// ----------------------------------------------------------------------------
// source_tokenizer_top_assert.svh
// Assertion macros for the tokenizer: implication now and on the next cycle.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKENIZER_TOP_ASSERT_SVH
`define SOURCE_TOKENIZER_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define STK_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define STK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/stk_pkg.sv]
// ----------------------------------------------------------------------------
// stk_pkg
// Shared types, codes and keyword tables of the source tokenizer.
// ----------------------------------------------------------------------------
package stk_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int MAX_RES         = 3;
  localparam int QDEPTH          = 8;
  localparam int Q_PTR_W         = $clog2(QDEPTH);
  localparam int Q_CNT_W         = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    KIND_LPAREN = 4'd0,
    KIND_RPAREN = 4'd1,
    KIND_LBRACE = 4'd2,
    KIND_RBRACE = 4'd3,
    KIND_SEMI   = 4'd4,
    KIND_FUNC   = 4'd5,
    KIND_RETURN = 4'd6,
    KIND_I32    = 4'd7,
    KIND_IDENT  = 4'd8,
    KIND_NUMBER = 4'd9,
    KIND_END    = 4'd10,
    KIND_ERROR  = 4'd11
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_IDENT = 2'd1,
    MODE_NUM   = 2'd2,
    MODE_DONE  = 2'd3
  } mode_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start_res;
    logic [15:0] length;
    logic        final_res;
  } res_t;

  typedef struct packed {
    mode_t mode;
  } lex_stat_t;

  // Keyword slots, matching the bit order of the hit vector.
  localparam logic [1:0] KW_I32    = 2'd0;
  localparam logic [1:0] KW_FUNC   = 2'd1;
  localparam logic [1:0] KW_RETURN = 2'd2;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_US  = 8'h5F;

  function automatic logic [47:0] kw_text(input logic [1:0] k);
    logic [47:0] w;
    case (k)
      KW_I32:    w = {24'h0, "2", "3", "i"};
      KW_FUNC:   w = {16'h0, "c", "n", "u", "f"};
      KW_RETURN: w = {"n", "r", "u", "t", "e", "r"};
      default:   w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] l;
    case (k)
      KW_I32:    l = 3'd3;
      KW_FUNC:   l = 3'd4;
      KW_RETURN: l = 3'd6;
      default:   l = 3'd0;
    endcase
    return l;
  endfunction

  // Drop every keyword that the byte at offset len of the token cannot continue.
  function automatic logic [2:0] kw_update(input logic [2:0] hits, input logic [15:0] len,
                                           input logic [7:0] c);
    logic [2:0]  h;
    logic [47:0] w;
    h = hits;
    for (int k = 0; k < 3; k++) begin
      w = kw_text(2'(k));
      if (len >= {13'b0, kw_len(2'(k))})
        h[k] = 1'b0;
      else if (w[{len[2:0], 3'b000} +: 8] != c)
        h[k] = 1'b0;
    end
    return h;
  endfunction

  function automatic kind_t ident_kind(input logic [2:0] hits, input logic [15:0] len);
    kind_t kd;
    if (hits[KW_I32] && len == 16'd3)
      kd = KIND_I32;
    else if (hits[KW_FUNC] && len == 16'd4)
      kd = KIND_FUNC;
    else if (hits[KW_RETURN] && len == 16'd6)
      kd = KIND_RETURN;
    else
      kd = KIND_IDENT;
    return kd;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

endpackage

[rtl/stk_lex.sv]
// ----------------------------------------------------------------------------
// stk_lex
// Lexer state and the per-byte step: up to three compacted results a byte.
// ----------------------------------------------------------------------------
module stk_lex #(
  parameter int OFFSET_BITS = stk_pkg::OFFSET_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fire,
  input  logic [7:0]                           ch,
  input  logic                                 last,
  output logic [1:0]                           res_n,
  output stk_pkg::res_t [stk_pkg::MAX_RES-1:0] res,
  output stk_pkg::lex_stat_t                   stat
);
  import stk_pkg::*;

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  mode_t                  mode_r, mode_nxt;
  logic [15:0]            tstart_r, tstart_nxt;
  logic [15:0]            tlen_r, tlen_nxt;
  logic [2:0]             hits_r, hits_nxt;

  logic [OFFSET_BITS+15:0] pos_ext, posn_ext;
  logic [15:0]             pos16, posn16;
  logic [OFFSET_BITS-1:0]  pos_step;

  logic       is_letter, is_digit, is_ws, is_punct;
  kind_t      punct_kind;
  res_t [2:0] slot;
  logic [2:0] slot_v;

  // Offsets leave the lexer saturated to 16 bits.
  assign pos_ext  = {16'b0, pos_r};
  assign pos16    = (|pos_ext[OFFSET_BITS+15:16]) ? 16'hFFFF : pos_ext[15:0];
  assign posn_ext = {16'b0, pos_step};
  assign posn16   = (|posn_ext[OFFSET_BITS+15:16]) ? 16'hFFFF : posn_ext[15:0];
  assign pos_step = (pos_r != {OFFSET_BITS{1'b1}}) ? pos_r + 1'b1 : pos_r;

  assign is_letter = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == CH_US;
  assign is_digit  = ch >= "0" && ch <= "9";
  assign is_ws     = ch == " " || ch == 8'h09 || ch == 8'h0D || ch == 8'h0A;

  always_comb begin
    is_punct   = 1'b1;
    punct_kind = KIND_LPAREN;
    case (ch)
      "(":     punct_kind = KIND_LPAREN;
      ")":     punct_kind = KIND_RPAREN;
      "{":     punct_kind = KIND_LBRACE;
      "}":     punct_kind = KIND_RBRACE;
      ";":     punct_kind = KIND_SEMI;
      default: is_punct = 1'b0;
    endcase
  end

  always_comb begin
    pos_nxt    = pos_r;
    mode_nxt   = mode_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    hits_nxt   = hits_r;
    slot       = '0;
    slot_v     = '0;

    // Slot 0: the token closed by this byte.
    slot[0].kind      = (mode_r == MODE_NUM) ? KIND_NUMBER : ident_kind(hits_r, tlen_r);
    slot[0].start_res = tstart_r;
    slot[0].length    = tlen_r;

    if (mode_r != MODE_DONE) begin
      if (ch == CH_NUL) begin
        slot_v[0] = mode_r != MODE_IDLE;
        slot_v[1] = 1'b1;
        slot[1]   = '{kind: KIND_END, start_res: pos16, length: 16'd0, final_res: 1'b0};
        mode_nxt  = MODE_DONE;
      end else if (mode_r == MODE_IDENT && (is_letter || is_digit)) begin
        hits_nxt = kw_update(hits_r, tlen_r, ch);
        tlen_nxt = sat_inc16(tlen_r);
      end else if (mode_r == MODE_NUM && is_digit) begin
        tlen_nxt = sat_inc16(tlen_r);
      end else begin
        slot_v[0] = mode_r != MODE_IDLE;
        mode_nxt  = MODE_IDLE;
        if (is_ws) begin
          slot_v[1] = 1'b0;
        end else if (is_punct) begin
          slot_v[1] = 1'b1;
          slot[1]   = '{kind: punct_kind, start_res: pos16, length: 16'd1, final_res: 1'b0};
        end else if (is_letter) begin
          mode_nxt   = MODE_IDENT;
          tstart_nxt = pos16;
          tlen_nxt   = 16'd1;
          hits_nxt   = kw_update(3'b111, 16'd0, ch);
        end else if (is_digit) begin
          mode_nxt   = MODE_NUM;
          tstart_nxt = pos16;
          tlen_nxt   = 16'd1;
        end else begin
          slot_v[1] = 1'b1;
          slot[1]   = '{kind: KIND_ERROR, start_res: pos16, length: 16'd1, final_res: 1'b0};
          mode_nxt  = MODE_DONE;
        end
      end

      if (mode_nxt != MODE_DONE)
        pos_nxt = pos_step;

      // Last byte: close whatever token is still open, then END.
      if (last && mode_nxt != MODE_DONE) begin
        if (mode_nxt != MODE_IDLE) begin
          slot_v[1]         = 1'b1;
          slot[1].kind      = (mode_nxt == MODE_NUM) ? KIND_NUMBER
                                                     : ident_kind(hits_nxt, tlen_nxt);
          slot[1].start_res = tstart_nxt;
          slot[1].length    = tlen_nxt;
        end
        slot_v[2] = 1'b1;
        slot[2]   = '{kind: KIND_END, start_res: posn16, length: 16'd0, final_res: 1'b0};
      end
    end

    slot[0].final_res = !slot_v[1] && !slot_v[2];
    slot[1].final_res = !slot_v[2];
    slot[2].final_res = 1'b1;

    if (last) begin
      pos_nxt    = '0;
      mode_nxt   = MODE_IDLE;
      tstart_nxt = '0;
      tlen_nxt   = '0;
      hits_nxt   = 3'b111;
    end
  end

  // Pack the valid slots toward index zero.
  always_comb begin
    res   = '0;
    res_n = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (slot_v[i]) begin
        res[res_n] = slot[i];
        res_n      = res_n + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      mode_r   <= MODE_IDLE;
      tstart_r <= '0;
      tlen_r   <= '0;
      hits_r   <= 3'b111;
    end else if (fire) begin
      pos_r    <= pos_nxt;
      mode_r   <= mode_nxt;
      tstart_r <= tstart_nxt;
      tlen_r   <= tlen_nxt;
      hits_r   <= hits_nxt;
    end
  end

  assign stat.mode = mode_r;

endmodule

[rtl/stk_queue.sv]
// ----------------------------------------------------------------------------
// stk_queue
// Result queue: takes up to three results a cycle, hands out one.
// ----------------------------------------------------------------------------
module stk_queue (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  input  logic [1:0]                           push_n,
  input  stk_pkg::res_t [stk_pkg::MAX_RES-1:0] push_data,
  input  logic                                 pop,
  output stk_pkg::res_t                        head,
  output logic                                 not_empty,
  output logic                                 room,
  output logic [stk_pkg::Q_CNT_W-1:0]          count
);
  import stk_pkg::*;

  res_t               mem_r [QDEPTH];
  logic [Q_PTR_W-1:0] wr_r, rd_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic [Q_CNT_W-1:0] add_n, sub_n;

  assign add_n     = push ? Q_CNT_W'(push_n) : '0;
  assign sub_n     = pop  ? Q_CNT_W'(1)      : '0;
  assign not_empty = cnt_r != '0;
  assign room      = cnt_r <= Q_CNT_W'(QDEPTH - MAX_RES);
  assign head      = mem_r[rd_r];
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + Q_PTR_W'(add_n);
      rd_r  <= rd_r + Q_PTR_W'(sub_n);
      cnt_r <= cnt_r + add_n - sub_n;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (push && 2'(i) < push_n)
        mem_r[wr_r + Q_PTR_W'(i)] <= push_data[i];
    end
  end

endmodule

[rtl/source_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// source_tokenizer_top
// Streaming lexer: one source byte per request in, tokens out.
// A held byte's results are pushed into the result queue once it has room; the queue head is offered.
// Throughput: one byte per cycle while bytes yield at most one result each; the
//   eight-entry result queue, drained one result per cycle while out_tready is high, sets the sustained rate.
// Reset: rst_n low at a clock edge clears lexer state, input register and queue.
// ----------------------------------------------------------------------------
module source_tokenizer_top #(
  parameter int OFFSET_BITS = stk_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // last byte of the program
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] start_res, [31:16] length
  output logic [3:0]  out_tuser,  // [3:0] kind
  output logic        out_tlast   // final result caused by the byte
);
  import stk_pkg::*;

  `include "source_tokenizer_top_assert.svh"

  // Input register: hold one byte until the queue has room for its results.
  logic       in_v_r;
  logic [7:0] in_ch_r;
  logic       in_last_r;
  logic       fire;
  logic       q_room;
  logic       q_not_empty;
  logic       pop;

  logic [Q_CNT_W-1:0]         q_count;
  logic [1:0]                 res_n;
  res_t [MAX_RES-1:0]         res;
  res_t                       head;
  lex_stat_t                  lex_stat;

  // Advance the held byte only when the queue can absorb a worst-case burst.
  assign fire      = in_v_r && q_room;
  assign in_tready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_ch_r   <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Step the lexer on the held byte; it yields zero to three results.
  stk_lex #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_lex (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .ch    (in_ch_r),
    .last  (in_last_r),
    .res_n (res_n),
    .res   (res),
    .stat  (lex_stat)
  );

  // Queue the results; the head drives the output channel directly.
  stk_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .push_n    (res_n),
    .push_data (res),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .room      (q_room),
    .count     (q_count)
  );

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = q_not_empty;
  assign out_tdata  = {head.length, head.start_res};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.final_res;

  // ---- assertions ----
  `STK_ASSERT(a_queue_bound, 1'b1, q_count <= Q_CNT_W'(QDEPTH), "result queue overfilled")
  `STK_ASSERT(a_push_fits, fire, (q_count + Q_CNT_W'(res_n)) <= Q_CNT_W'(QDEPTH), "push overruns queue")
  `STK_ASSERT_NEXT(a_in_hold, in_v_r && !fire, in_v_r && $stable(in_ch_r), "held byte lost")
  `STK_ASSERT(a_done_quiet, fire && lex_stat.mode == MODE_DONE, res_n == 2'd0, "result after end")

endmodule
